@@ hdl/wwms_pkg.sv @@
// Shared types and constants of the weekly window motion scheduler.
// No dependencies; every other file of the block imports this package.
package wwms_pkg;

   // Number of schedule entries and the derived index and counter widths.
   localparam int NUM_ENTRIES = 16;
   localparam int ENTRY_AW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);

   // Fixed widths of the channel fields.
   localparam int MINUTE_W   = 11;
   localparam int INDEX_W    = 4;
   localparam int DAY_W      = 3;
   localparam int MASK_W     = 7;
   localparam int MKIND_W    = 3;
   localparam int MNUM_W     = 8;

   // Request kinds.
   localparam logic [1:0] KIND_TICK    = 2'd0;
   localparam logic [1:0] KIND_SET     = 2'd1;
   localparam logic [1:0] KIND_DISABLE = 2'd2;
   localparam logic [1:0] KIND_CLEAR   = 2'd3;

   // Response actions and status codes.
   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_STOP  = 2'd2;

   localparam logic ST_OK     = 1'b0;
   localparam logic ST_REJECT = 1'b1;

   // Motion kind of a cleared entry and the last minute of a day.
   localparam logic [MKIND_W-1:0]  MKIND_CRUISE = 3'd3;
   localparam logic [MINUTE_W-1:0] DEFAULT_END  = 11'd1439;

   typedef struct packed {
      logic [1:0]          kind;
      logic [INDEX_W-1:0]  entry_index;
      logic [DAY_W-1:0]    day_of_week;
      logic [MINUTE_W-1:0] minute_of_day;
      logic [MINUTE_W-1:0] window_begin;
      logic [MINUTE_W-1:0] window_end;
      logic [MASK_W-1:0]   day_mask;
      logic [MKIND_W-1:0]  motion_kind;
      logic [MNUM_W-1:0]   motion_number;
      logic                entry_enable;
      logic                entry_valid;
   } req_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [INDEX_W-1:0] event_entry;
      logic [MKIND_W-1:0] event_motion_kind;
      logic [MNUM_W-1:0]  event_motion_number;
      logic               status;
      logic               last;
   } rsp_type;

   // One stored schedule entry, 42 bits.
   typedef struct packed {
      logic [MINUTE_W-1:0] win_first;
      logic [MINUTE_W-1:0] win_last;
      logic [MASK_W-1:0]   day_mask;
      logic [MKIND_W-1:0]  mkind;
      logic [MNUM_W-1:0]   mnum;
      logic                enable;
      logic                valid;
   } entry_type;

   localparam entry_type ENTRY_DEFAULT = '{
      win_first: '0,
      win_last:  DEFAULT_END,
      day_mask:  '0,
      mkind:     MKIND_CRUISE,
      mnum:      '0,
      enable:    1'b0,
      valid:     1'b0
   };

   // Read and write command for the entry table.
   typedef struct packed {
      logic                rd_en;
      logic [ENTRY_AW-1:0] rd_addr;
      logic                wr_en;
      logic [ENTRY_AW-1:0] wr_addr;
      entry_type           wr_data;
   } tbl_cmd_type;

endpackage

@@ hdl/wwms_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on wwms_pkg for the payload types.
interface wwms_req_if;
   import wwms_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface wwms_rsp_if;
   import wwms_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/wwms_table.sv @@
// Entry table: one synchronous memory with a registered read port.
// Depends on wwms_pkg. Entries never written since reset read as defaults.
module wwms_table (
   input  logic                      clock,
   input  logic                      reset,
   input  wwms_pkg::tbl_cmd_type     cmd,
   output wwms_pkg::entry_type       rd_data
);
   import wwms_pkg::*;

   entry_type              mem_ff [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] init_ff;
   logic [NUM_ENTRIES-1:0] init_in;
   entry_type              rdq_ff;
   logic                   rd_init_ff;

   always_comb begin
      init_in = init_ff;
      if (cmd.wr_en) begin
         init_in[cmd.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= '0;
      end else begin
         init_ff <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rdq_ff     <= mem_ff[cmd.rd_addr];
         rd_init_ff <= init_ff[cmd.rd_addr];
      end
   end

   assign rd_data = rd_init_ff ? rdq_ff : ENTRY_DEFAULT;

endmodule

@@ hdl/wwms_seq.sv @@
// Sequencer: accepts requests, walks the entry table on a tick, edits entries,
// keeps the running flags and drives the response register. Uses wwms_pkg.
module wwms_seq (
   input  logic                  clock,
   input  logic                  reset,
   wwms_req_if.sink              req_bus,
   wwms_rsp_if.source            rsp_bus,
   output wwms_pkg::tbl_cmd_type tbl_cmd,
   input  wwms_pkg::entry_type   rd_data
);
   import wwms_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EDIT = 4'b0010,
      S_WALK = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   e_vld_ff, e_vld_in;
   logic [ENTRY_AW-1:0]    e_idx_ff, e_idx_in;
   logic [NUM_ENTRIES-1:0] run_ff, run_in;
   logic                   pend_vld_ff, pend_vld_in;
   rsp_type                pend_ff, pend_in;
   logic                   out_vld_ff, out_vld_in;
   rsp_type                out_ff, out_in;

   logic                   accept;
   logic                   out_free;
   logic [MASK_W:0]        mask_ext;
   logic                   active;
   logic                   run_bit;
   logic                   evt;
   logic                   can_go;
   logic                   advance;
   logic                   more;
   logic                   idx_ok;
   logic                   reject;
   rsp_type                evt_rsp;
   rsp_type                none_rsp;

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !out_vld_ff || rsp_bus.ready;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign rsp_bus.valid = out_vld_ff;
   assign rsp_bus.data  = out_ff;

   // Match of the entry in the evaluate stage against the tick.
   assign mask_ext = {1'b0, rd_data.day_mask};
   assign active   = rd_data.valid && rd_data.enable
                     && mask_ext[req_ff.day_of_week]
                     && (rd_data.win_first <= req_ff.minute_of_day)
                     && (rd_data.win_last >= req_ff.minute_of_day);
   assign run_bit  = run_ff[e_idx_ff];
   assign evt      = e_vld_ff && (active != run_bit);
   assign can_go   = !pend_vld_ff || out_free;
   assign advance  = !evt || can_go;
   assign more     = (cnt_ff < CNT_W'(NUM_ENTRIES));
   assign idx_ok   = (int'(req_ff.entry_index) < NUM_ENTRIES);
   assign reject   = (req_ff.window_begin >= req_ff.window_end);

   always_comb begin
      evt_rsp                     = '0;
      evt_rsp.action              = active ? ACT_START : ACT_STOP;
      evt_rsp.event_entry         = INDEX_W'(e_idx_ff);
      evt_rsp.event_motion_kind   = rd_data.mkind;
      evt_rsp.event_motion_number = rd_data.mnum;
      evt_rsp.status              = ST_OK;
      none_rsp                    = '0;
      none_rsp.action             = ACT_NONE;
      none_rsp.status             = ST_OK;
      none_rsp.last               = 1'b1;
   end

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      cnt_in      = cnt_ff;
      e_vld_in    = e_vld_ff;
      e_idx_in    = e_idx_ff;
      run_in      = run_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      out_vld_in  = out_vld_ff && !rsp_bus.ready;
      out_in      = out_ff;
      tbl_cmd     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_bus.data;
               if (req_bus.data.kind == KIND_TICK) begin
                  cnt_in   = '0;
                  e_vld_in = 1'b0;
                  state_in = S_WALK;
               end else begin
                  tbl_cmd.rd_en   = 1'b1;
                  tbl_cmd.rd_addr = ENTRY_AW'(req_bus.data.entry_index);
                  state_in        = S_EDIT;
               end
            end
         end

         S_EDIT: begin
            if (out_free) begin
               out_vld_in      = 1'b1;
               out_in          = none_rsp;
               tbl_cmd.wr_addr = ENTRY_AW'(req_ff.entry_index);
               state_in        = S_IDLE;
               if (idx_ok) begin
                  unique case (req_ff.kind)
                     KIND_SET: begin
                        if (reject) begin
                           out_in.status = ST_REJECT;
                        end else begin
                           if (req_ff.entry_valid) begin
                              if (req_ff.entry_enable) begin
                                 run_in = '0;
                              end else if (rd_data.enable) begin
                                 out_in.action              = ACT_STOP;
                                 out_in.event_entry         = req_ff.entry_index;
                                 out_in.event_motion_kind   = rd_data.mkind;
                                 out_in.event_motion_number = rd_data.mnum;
                              end
                           end
                           tbl_cmd.wr_en             = 1'b1;
                           tbl_cmd.wr_data.win_first = req_ff.window_begin;
                           tbl_cmd.wr_data.win_last  = req_ff.window_end;
                           tbl_cmd.wr_data.day_mask  = req_ff.day_mask;
                           tbl_cmd.wr_data.mkind     = req_ff.motion_kind;
                           tbl_cmd.wr_data.mnum      = req_ff.motion_number;
                           tbl_cmd.wr_data.enable    = req_ff.entry_enable;
                           tbl_cmd.wr_data.valid     = req_ff.entry_valid;
                        end
                     end
                     KIND_DISABLE: begin
                        if (rd_data.valid) begin
                           tbl_cmd.wr_en          = 1'b1;
                           tbl_cmd.wr_data        = rd_data;
                           tbl_cmd.wr_data.enable = 1'b0;
                        end
                     end
                     KIND_CLEAR: begin
                        tbl_cmd.wr_en   = 1'b1;
                        tbl_cmd.wr_data = ENTRY_DEFAULT;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         S_WALK: begin
            // Evaluate stage: an event goes to the holding register, pushing
            // the one held before into the response register.
            if (evt && can_go) begin
               run_in[e_idx_ff] = active;
               pend_vld_in      = 1'b1;
               pend_in          = evt_rsp;
               if (pend_vld_ff) begin
                  out_vld_in = 1'b1;
                  out_in     = pend_ff;
               end
            end
            // Read stage: the next entry is read once the evaluate stage moves.
            if (advance) begin
               if (more) begin
                  tbl_cmd.rd_en   = 1'b1;
                  tbl_cmd.rd_addr = cnt_ff[ENTRY_AW-1:0];
                  e_idx_in        = cnt_ff[ENTRY_AW-1:0];
                  e_vld_in        = 1'b1;
                  cnt_in          = cnt_ff + CNT_W'(1);
               end else begin
                  e_vld_in = 1'b0;
               end
            end
            if (!e_vld_ff && !more) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (out_free) begin
               out_vld_in  = 1'b1;
               out_in      = none_rsp;
               if (pend_vld_ff) begin
                  out_in      = pend_ff;
                  out_in.last = 1'b1;
               end
               pend_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= '0;
         e_vld_ff    <= 1'b0;
         run_ff      <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         e_vld_ff    <= e_vld_in;
         run_ff      <= run_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      e_idx_ff <= e_idx_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end

`ifndef NO_ASSERTIONS
   // The table is never written while a tick walks it.
   a_no_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> !tbl_cmd.wr_en)
      else $error("table written during tick walk");

   // A response that is not the final one can only come from a tick.
   a_inner_from_tick: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_ff.last) |-> (req_ff.kind == KIND_TICK))
      else $error("non-final response outside a tick");

   // The holding register is empty whenever the block waits for a request.
   a_pend_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_vld_ff)
      else $error("held event left over after a request");

   // Closing a tick always presents a final response on the next cycle.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (out_vld_ff && out_ff.last))
      else $error("tick closed without a final response");
`endif

endmodule

@@ hdl/weekly_window_motion_scheduler.sv @@
// Top level of the weekly window motion scheduler.
// Depends on wwms_pkg, the interfaces in wwms_if, wwms_table and wwms_seq.
//
//   channel   modport        handshake       payload
//   req_bus   wwms_req_if    valid / ready   req_type: tick, set, disable, clear
//   rsp_bus   wwms_rsp_if    valid / ready   rsp_type: action, entry, motion, status, last
//
// A request is taken only while the block is idle; one request is handled at a time.
// A set, disable or clear first reads the addressed entry from the table memory, then,
// once the response side is free, writes back any change and loads the single response.
// A tick walks the table memory one entry per cycle through its registered read port
// while the response side keeps up.
// Reset (synchronous, active high) clears the running flags and marks every entry as
// unwritten, so it reads as the default entry at once; no clearing pass is needed.
// When the response side stalls, the walk holds on the entry in its evaluate stage.
module weekly_window_motion_scheduler (
   input logic        clock,
   input logic        reset,
   wwms_req_if.sink   req_bus,
   wwms_rsp_if.source rsp_bus
);
   import wwms_pkg::*;

   tbl_cmd_type tbl_cmd;
   entry_type   rd_data;

   // The schedule table: begin and end minute, weekday mask, motion and the
   // enable and valid bits of every entry, in one memory.
   wwms_table u_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tbl_cmd),
      .rd_data (rd_data)
   );

   // The sequencer owns the running flags. On a tick it holds back the newest
   // event in a holding register so that the final event of the walk can carry
   // the last mark; a tick without events answers with a single no-event response.
   // Edits are read-modify-write on one entry, and because requests are taken
   // one at a time a read never overlaps a write of the same entry.
   wwms_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .tbl_cmd (tbl_cmd),
      .rd_data (rd_data)
   );

endmodule

@@ tb/sv/tb_weekly_window_motion_scheduler.sv @@
// Self-checking testbench for the weekly window motion scheduler: directed and random
// tick, set, disable and clear requests, each checked against an in-bench schedule model.
// Depends on wwms_pkg, the channel interfaces in wwms_if and the top level of the block.
module tb_weekly_window_motion_scheduler;
   import wwms_pkg::*;

   // Requests at the end of the stimulus that run with neither side idling.
   localparam int QUIET_TAIL       = 25;
   // The response side holds off once, after this many requests, for this many cycles.
   localparam int LONG_HOLD_AT     = 40;
   localparam int LONG_HOLD_CYCLES = 300;
   // Settling time after the last response.
   localparam int SETTLE_CYCLES    = 50;
   // Hard limit on the run, far above the slowest correct run.
   localparam int RUN_LIMIT        = 2000000;

   // A queued request, optionally held back until every earlier request has finished.
   typedef struct {
      req_type req;
      bit      hold_for_drain;
   } queued_req_type;

   logic clock = 1'b0;
   logic reset;

   wwms_req_if req_bus ();
   wwms_rsp_if rsp_bus ();

   weekly_window_motion_scheduler u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // Stimulus not yet offered, and responses predicted but not yet seen.
   queued_req_type pending_reqs[$];
   rsp_type        events_due[$];

   // Schedule model: the entry table and the running flag of every entry.
   entry_type             model_entries [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] model_running;

   // Progress counters. reqs_sent counts accepted requests, reqs_done counts responses
   // that carried the last flag. Both change by nonblocking assignment only, so every
   // process reads the same value at a given clock edge.
   int unsigned reqs_sent  = 0;
   int unsigned reqs_done  = 0;
   int unsigned total_reqs = 0;
   int          err_count  = 0;

   // Set once the stimulus reaches its tail; both sides then stop idling.
   bit quiet = 1'b0;

   int unsigned send_gap       = 0;
   int unsigned stall_left     = 0;
   int unsigned long_hold_left = 0;
   bit          long_hold_done = 1'b0;

   // ------------------------------------------------------------------------------------
   // Schedule model. Works out every response that one accepted request causes and
   // updates the model state the same way the block is meant to.
   // ------------------------------------------------------------------------------------
   function automatic void predict_events(input req_type r);
      rsp_type   batch[$];
      rsp_type   ev;
      entry_type cur;
      logic      on_day;
      logic      active;

      if (r.kind == KIND_TICK) begin
         // Walk the table in index order. An active entry that is not running starts,
         // a running entry that is no longer active stops with its current motion.
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            cur    = model_entries[i];
            // Weekday seven shifts every mask bit out, so it matches no entry.
            on_day = |(({1'b0, cur.day_mask} >> r.day_of_week) & 8'h01);
            active = cur.valid && cur.enable && on_day &&
                     (cur.win_first <= r.minute_of_day) &&
                     (cur.win_last >= r.minute_of_day);
            if (active != model_running[i]) begin
               ev                     = '0;
               ev.action              = active ? ACT_START : ACT_STOP;
               ev.event_entry         = INDEX_W'(i);
               ev.event_motion_kind   = cur.mkind;
               ev.event_motion_number = cur.mnum;
               batch.push_back(ev);
               model_running[i] = active;
            end
         end
      end else if (r.entry_index < NUM_ENTRIES) begin
         cur = model_entries[r.entry_index];
         case (r.kind)
            KIND_SET: begin
               if (r.window_begin >= r.window_end) begin
                  // An empty or reversed window is refused and changes nothing.
                  ev        = '0;
                  ev.status = ST_REJECT;
                  batch.push_back(ev);
               end else begin
                  if (r.entry_valid && r.entry_enable) begin
                     // The worker restarts, so nothing counts as running any more.
                     model_running = '0;
                  end else if (r.entry_valid && cur.enable) begin
                     // Disabling a live entry stops the motion it held; the flag stays.
                     ev                     = '0;
                     ev.action              = ACT_STOP;
                     ev.event_entry         = r.entry_index;
                     ev.event_motion_kind   = cur.mkind;
                     ev.event_motion_number = cur.mnum;
                     batch.push_back(ev);
                  end
                  cur.win_first = r.window_begin;
                  cur.win_last  = r.window_end;
                  cur.day_mask  = r.day_mask;
                  cur.mkind     = r.motion_kind;
                  cur.mnum      = r.motion_number;
                  cur.enable    = r.entry_enable;
                  cur.valid     = r.entry_valid;
                  model_entries[r.entry_index] = cur;
               end
            end
            KIND_DISABLE: begin
               if (cur.valid)
                  model_entries[r.entry_index].enable = 1'b0;
            end
            default: begin
               // Clear restores the defaults but leaves the running flag alone.
               model_entries[r.entry_index] = ENTRY_DEFAULT;
            end
         endcase
      end

      // Every request answers at least once; the final response carries the last flag.
      if (batch.size() == 0) begin
         ev = '0;
         batch.push_back(ev);
      end
      batch[batch.size()-1].last = 1'b1;
      foreach (batch[k])
         events_due.push_back(batch[k]);
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endtask

   // ------------------------------------------------------------------------------------
   // Request builders. Unused fields keep random bits so that the block is seen to
   // ignore them.
   // ------------------------------------------------------------------------------------
   function automatic req_type noisy_req();
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      return noise[$bits(req_type)-1:0];
   endfunction

   function automatic req_type tick_req(input int day, input int minute);
      req_type r;
      r               = noisy_req();
      r.kind          = KIND_TICK;
      r.day_of_week   = DAY_W'(day);
      r.minute_of_day = MINUTE_W'(minute);
      return r;
   endfunction

   function automatic req_type set_req(input int idx, input int first, input int last_min,
                                       input int mask, input int mkind, input int mnum,
                                       input bit en, input bit val);
      req_type r;
      r               = noisy_req();
      r.kind          = KIND_SET;
      r.entry_index   = INDEX_W'(idx);
      r.window_begin  = MINUTE_W'(first);
      r.window_end    = MINUTE_W'(last_min);
      r.day_mask      = MASK_W'(mask);
      r.motion_kind   = MKIND_W'(mkind);
      r.motion_number = MNUM_W'(mnum);
      r.entry_enable  = en;
      r.entry_valid   = val;
      return r;
   endfunction

   function automatic req_type edit_req(input logic [1:0] kind, input int idx);
      req_type r;
      r             = noisy_req();
      r.kind        = kind;
      r.entry_index = INDEX_W'(idx);
      return r;
   endfunction

   task automatic queue_req(input req_type r, input bit drain);
      queued_req_type q;
      q.req            = r;
      q.hold_for_drain = drain;
      pending_reqs.push_back(q);
   endtask

   // One random request. Ticks dominate, most sets are well formed with wide windows
   // so that ticks land inside them, and the rest is edits and malformed sets.
   function automatic req_type random_req();
      int pick;
      int first;
      int last_min;
      int mask;
      bit en;
      bit val;

      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         return tick_req(($urandom_range(0, 15) == 0) ? 7 : $urandom_range(0, 6),
                         ($urandom_range(0, 15) == 0) ? $urandom_range(1440, 2047)
                                                      : $urandom_range(0, 1439));
      end else if (pick < 75) begin
         if ($urandom_range(0, 6) == 0) begin
            // Any pair of window bounds, including empty and reversed windows.
            first    = $urandom_range(0, 2047);
            last_min = ($urandom_range(0, 3) == 0) ? first : $urandom_range(0, 2047);
         end else if ($urandom_range(0, 1) == 0) begin
            first    = $urandom_range(0, 700);
            last_min = $urandom_range(800, 1439);
         end else begin
            first    = $urandom_range(0, 1438);
            last_min = $urandom_range(first + 1, 1439);
         end
         mask = ($urandom_range(0, 1) == 0) ? 7'h7F : $urandom_range(0, 127);
         if ($urandom_range(0, 9) < 7) begin
            en  = 1'b1;
            val = 1'b1;
         end else begin
            en  = 1'($urandom_range(0, 1));
            val = 1'($urandom_range(0, 1));
         end
         return set_req($urandom_range(0, 15), first, last_min, mask,
                        $urandom_range(0, 7), $urandom_range(0, 255), en, val);
      end else if (pick < 88) begin
         return edit_req(KIND_DISABLE, $urandom_range(0, 15));
      end else begin
         return edit_req(KIND_CLEAR, $urandom_range(0, 15));
      end
   endfunction

   // ------------------------------------------------------------------------------------
   // Request driver. A new request is loaded when the channel is empty or the current
   // one is taken at this edge. Idle gaps fall in at random until the quiet tail.
   // A request marked hold_for_drain waits until every earlier request has sent its
   // last response.
   // ------------------------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      int unsigned sent_now;

      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         sent_now  = reqs_sent + ((req_bus.valid && req_bus.ready) ? 1 : 0);
         reqs_sent <= sent_now;
         quiet     <= (sent_now + QUIET_TAIL >= total_reqs);
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               req_bus.valid <= 1'b0;
               send_gap      <= send_gap - 1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
               req_bus.valid <= 1'b0;
               send_gap      <= $urandom_range(0, 6);
            end else if (pending_reqs.size() > 0 &&
                         (!pending_reqs[0].hold_for_drain || sent_now == reqs_done)) begin
               req_bus.valid <= 1'b1;
               req_bus.data  <= pending_reqs[0].req;
               pending_reqs.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Response receiver. Ready drops in random bursts, and once for a long stretch while
   // the driver keeps offering, so that the block backs up and holds its input. No
   // stalls in the quiet tail.
   // ------------------------------------------------------------------------------------
   always @(posedge clock) begin : drive_ready
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (long_hold_left > 0) begin
         rsp_bus.ready  <= 1'b0;
         long_hold_left <= long_hold_left - 1;
      end else if (!long_hold_done && reqs_sent >= LONG_HOLD_AT) begin
         rsp_bus.ready  <= 1'b0;
         long_hold_left <= LONG_HOLD_CYCLES - 1;
         long_hold_done <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= $urandom_range(0, 6);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------------------
   // Monitor. Both channels are sampled in one process, so a request is always
   // predicted before any response that it causes is compared.
   // ------------------------------------------------------------------------------------
   always @(posedge clock) begin : watch_channels
      rsp_type want;

      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            predict_events(req_bus.data);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (rsp_bus.data.last)
               reqs_done <= reqs_done + 1;
            if (events_due.size() == 0) begin
               $error("response with nothing expected: %p", rsp_bus.data);
               err_count++;
            end else begin
               want = events_due.pop_front();
               check_field("action", want.action, rsp_bus.data.action);
               check_field("event_entry", want.event_entry, rsp_bus.data.event_entry);
               check_field("event_motion_kind", want.event_motion_kind,
                           rsp_bus.data.event_motion_kind);
               check_field("event_motion_number", want.event_motion_number,
                           rsp_bus.data.event_motion_number);
               check_field("status", want.status, rsp_bus.data.status);
               check_field("last", want.last, rsp_bus.data.last);
            end
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Stimulus, reset and end of run.
   // ------------------------------------------------------------------------------------
   initial begin : run_sequence
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      rsp_bus.ready = 1'b0;
      reset         = 1'b1;

      foreach (model_entries[i])
         model_entries[i] = ENTRY_DEFAULT;
      model_running = '0;

      // Directed part. A tick straight after reset finds nothing to do.
      queue_req(tick_req(0, 0), 1'b0);
      // Full day on every weekday at entry 0, last two minutes of day 6 at entry 15.
      queue_req(set_req(0, 0, 1439, 7'h7F, 0, 0, 1'b1, 1'b1), 1'b0);
      queue_req(set_req(15, 1438, 1439, 7'h40, 7, 255, 1'b1, 1'b1), 1'b0);
      // Equal bounds and reversed bounds are both refused.
      queue_req(set_req(5, 100, 100, 7'h7F, 1, 1, 1'b1, 1'b1), 1'b0);
      queue_req(set_req(6, 2047, 0, 7'h7F, 1, 1, 1'b1, 1'b1), 1'b0);
      // Last minute of day 6 starts both entries; minute 0 stops only entry 15.
      queue_req(tick_req(6, 1439), 1'b0);
      queue_req(tick_req(6, 0), 1'b0);
      // Weekday seven matches no mask bit, so entry 0 stops.
      queue_req(tick_req(7, 1439), 1'b0);
      // A minute past the end of the day lies outside every stored window.
      queue_req(tick_req(0, 2047), 1'b0);
      queue_req(tick_req(0, 500), 1'b0);
      // Disabling a live entry through a set stops the old motion and keeps the flag,
      // so the following tick stops it once more with the new motion.
      queue_req(set_req(0, 0, 1439, 7'h7F, 2, 9, 1'b0, 1'b1), 1'b1);
      queue_req(tick_req(0, 500), 1'b0);
      // An enabled set restarts the worker and clears every running flag.
      queue_req(set_req(3, 100, 200, 7'h01, 1, 8'h55, 1'b1, 1'b1), 1'b0);
      queue_req(tick_req(0, 150), 1'b0);
      queue_req(edit_req(KIND_DISABLE, 3), 1'b0);
      queue_req(tick_req(0, 150), 1'b0);
      // Disable on an entry that was never written does nothing.
      queue_req(edit_req(KIND_DISABLE, 9), 1'b0);
      queue_req(edit_req(KIND_CLEAR, 3), 1'b0);
      queue_req(edit_req(KIND_CLEAR, 0), 1'b0);
      // An enabled but invalid entry never fires and does not restart the worker.
      queue_req(set_req(4, 0, 1439, 7'h7F, 4, 1, 1'b1, 1'b0), 1'b0);
      queue_req(tick_req(2, 1024), 1'b0);
      // A window that ends past the day's last minute still matches minute 2047.
      queue_req(set_req(10, 0, 2047, 7'h7F, 2, 8'hAA, 1'b1, 1'b1), 1'b0);
      queue_req(tick_req(5, 2047), 1'b0);
      queue_req(set_req(4, 5, 6, 7'h00, 6, 8'h33, 1'b0, 1'b0), 1'b0);

      // Fill the whole table with wide windows, then start and stop all sixteen at once.
      for (int i = 0; i < NUM_ENTRIES; i++)
         queue_req(set_req(i, $urandom_range(0, 100), $urandom_range(1300, 1439), 7'h7F,
                           $urandom_range(0, 7), $urandom_range(0, 255), 1'b1, 1'b1),
                   i == 0);
      queue_req(tick_req($urandom_range(0, 6), 700), 1'b0);
      queue_req(tick_req(7, 700), 1'b0);

      // Random part. Now and then the driver waits for the block to drain first.
      for (int n = 0; n < 58; n++)
         queue_req(random_req(), $urandom_range(0, 19) == 0);

      total_reqs = pending_reqs.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait until every request is taken and has sent its last response.
      while (pending_reqs.size() != 0 || req_bus.valid || reqs_sent != reqs_done)
         @(posedge clock);
      // Give any stray response time to show up.
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (events_due.size() != 0) begin
         $error("%0d expected responses never arrived", events_due.size());
         err_count++;
      end

      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog for a block that hangs or never finishes a request.
   initial begin : watchdog
      #RUN_LIMIT;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
